/* sv/pip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    // Coordinate format of the item fields and the far end of the test ray.
    localparam int COORD_BITS = 16;
    localparam int RAY_FAR_X  = 50000;
    localparam int FAR_BITS   = 17;

    // Internal widths: extended coordinate, difference, cross product term.
    localparam int EW = (COORD_BITS > FAR_BITS) ? COORD_BITS : FAR_BITS;
    localparam int DW = EW + 1;
    localparam int PW = 2 * DW;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Orientation codes.
    localparam logic [1:0] ORI_COL = 2'd0;
    localparam logic [1:0] ORI_POS = 2'd1;
    localparam logic [1:0] ORI_NEG = 2'd2;

    typedef struct packed {
        logic                          mode;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic                          last_vertex;
    } in_t;

    typedef struct packed {
        logic        inside_res;
        logic        on_edge;
        logic [1:0]  status;
    } out_t;

endpackage

`default_nettype wire

/* sv/point_in_polygon_test.sv */
`timescale 1ns / 1ps
`default_nettype none

// Point-in-polygon tester. A load beat stores one vertex; its result is
// strobed on done in the next cycle, and busy stays low, so loads can follow
// each other in every cycle. A query beat against a polygon of N stored
// vertices raises busy: the vertex memory is read once per vertex, one edge
// enters the test pipeline per cycle, and the closing edge follows the last
// read. The query result is strobed on done in the same cycle as busy falls,
// and a new beat may be accepted in that cycle. A query that hits an edge
// through the point ends early. A query on an empty table answers like a
// load, with status empty. Results cannot be held off: done is high for
// exactly one cycle per accepted beat.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output      logic busy,
    input  wire in_t  item,
    output      logic done,
    output      out_t result
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;
    localparam logic signed [EW-1:0] FAR_X = EW'(RAY_FAR_X);

    // Point q lies in the bounding box of a and b.
    function automatic logic within_box(
        input logic signed [EW-1:0] ax, ay, qx, qy, bx, by);
        logic signed [EW-1:0] xlo, xhi, ylo, yhi;
        xlo = (ax < bx) ? ax : bx;
        xhi = (ax < bx) ? bx : ax;
        ylo = (ay < by) ? ay : by;
        yhi = (ay < by) ? by : ay;
        return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
    endfunction

    // Orientation code from the sign of a cross term.
    function automatic logic [1:0] ori_of(input logic signed [PW:0] v);
        if (v == '0) begin
            return ORI_COL;
        end
        return v[PW] ? ORI_NEG : ORI_POS;
    endfunction

    // Orientation of ray end, ray start, vertex: minus (far - px) * (vy - py).
    function automatic logic [1:0] ray_ori(
        input logic signed [DW-1:0] f, input logic signed [DW-1:0] u);
        if (f == '0 || u == '0) begin
            return ORI_COL;
        end
        return (f[DW-1] == u[DW-1]) ? ORI_NEG : ORI_POS;
    endfunction

    // Control and state registers.
    logic [0:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 closed_reg, closed_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        issue_reg, issue_next;
    logic                 par_reg, par_next;
    logic                 done_reg, done_next;
    out_t                 res_reg, res_next;
    logic                 rd_vld_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic                 wrap_reg, wrap_next;
    logic                 e_vld_reg, e_vld_next;
    logic                 e_last_reg;
    logic                 s1_vld_reg;
    logic                 s1_last_reg;

    // Payload registers.
    logic signed [EW-1:0] qx_reg, qy_reg;
    logic [2*COORD_BITS-1:0] rd_data_reg;
    logic signed [EW-1:0] prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic signed [EW-1:0] ea_x_reg, ea_y_reg, eb_x_reg, eb_y_reg;
    logic signed [EW-1:0] sa_x_reg, sa_y_reg, sb_x_reg, sb_y_reg;
    logic signed [PW-1:0] m1a_reg, m1b_reg, m2a_reg, m5a_reg, m5b_reg;

    // Vertex memory, x in the upper half and y in the lower half.
    logic [2*COORD_BITS-1:0] vtx_mem [MAX_VERTICES];

    logic                 accept;
    logic [CW-1:0]        cnt_base;
    logic                 full;
    logic                 wr_en;
    logic                 rd_en;
    logic                 finish;
    logic signed [EW-1:0] in_x, in_y, rd_x, rd_y;

    assign accept = start && !busy;
    assign busy   = (state_reg == ST_RUN);
    assign done   = done_reg;
    assign result = res_reg;

    assign in_x = {{(EW-COORD_BITS){item.coord_x[COORD_BITS-1]}}, item.coord_x};
    assign in_y = {{(EW-COORD_BITS){item.coord_y[COORD_BITS-1]}}, item.coord_y};
    assign rd_x = {{(EW-COORD_BITS){rd_data_reg[2*COORD_BITS-1]}},
                   rd_data_reg[2*COORD_BITS-1:COORD_BITS]};
    assign rd_y = {{(EW-COORD_BITS){rd_data_reg[COORD_BITS-1]}},
                   rd_data_reg[COORD_BITS-1:0]};

    // Load bookkeeping: a closed polygon restarts at the next load.
    assign cnt_base = closed_reg ? '0 : count_reg;
    assign full     = (cnt_base == CW'(MAX_VERTICES));
    assign wr_en    = accept && (item.mode == MODE_LOAD) && !full;

    // Stage two: edge decision on the registered cross terms.
    logic signed [DW-1:0] f_q, u_a, u_b;
    logic [1:0]           o1, o2, o3, o4, o5;
    logic                 on_box, meet, col_hit;
    logic signed [EW-1:0] far_x;

    assign far_x = FAR_X;
    assign f_q   = DW'(FAR_X) - DW'(qx_reg);
    assign u_a   = DW'(sa_y_reg) - DW'(qy_reg);
    assign u_b   = DW'(sb_y_reg) - DW'(qy_reg);

    always_comb
    begin
        o1 = ori_of((PW+1)'(m1a_reg) - (PW+1)'(m1b_reg));
        o2 = ori_of((PW+1)'(m2a_reg) - (PW+1)'(m1b_reg));
        o3 = ray_ori(f_q, u_a);
        o4 = ray_ori(f_q, u_b);
        o5 = ori_of((PW+1)'(m5a_reg) - (PW+1)'(m5b_reg));
        on_box = within_box(sa_x_reg, sa_y_reg, qx_reg, qy_reg, sb_x_reg, sb_y_reg);
        meet = ((o1 != o2) && (o3 != o4))
            || ((o1 == ORI_COL) && on_box)
            || ((o2 == ORI_COL)
                && within_box(sa_x_reg, sa_y_reg, far_x, qy_reg, sb_x_reg, sb_y_reg))
            || ((o3 == ORI_COL)
                && within_box(qx_reg, qy_reg, sa_x_reg, sa_y_reg, far_x, qy_reg))
            || ((o4 == ORI_COL)
                && within_box(qx_reg, qy_reg, sb_x_reg, sb_y_reg, far_x, qy_reg));
        col_hit = s1_vld_reg && meet && (o5 == ORI_COL);
    end

    assign finish = s1_vld_reg && (col_hit || s1_last_reg);

    // Sequencer: loads, empty queries, vertex reads and the query result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        n_next      = n_reg;
        issue_next  = issue_reg;
        par_next    = par_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        rd_en       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    res_next.inside_res = 1'b0;
                    res_next.on_edge    = 1'b0;
                    res_next.status     = STAT_OK;
                    if (item.mode == MODE_LOAD) begin
                        done_next   = 1'b1;
                        closed_next = item.last_vertex;
                        if (full) begin
                            count_next      = cnt_base;
                            res_next.status = STAT_FULL;
                        end else begin
                            count_next = cnt_base + CW'(1);
                        end
                    end else if (count_reg == '0) begin
                        done_next       = 1'b1;
                        res_next.status = STAT_EMPTY;
                    end else begin
                        state_next = ST_RUN;
                        n_next     = count_reg;
                        issue_next = '0;
                        par_next   = 1'b0;
                    end
                end
            end
            ST_RUN:
            begin
                if (finish) begin
                    state_next          = ST_IDLE;
                    done_next           = 1'b1;
                    res_next.status     = STAT_OK;
                    res_next.on_edge    = col_hit;
                    res_next.inside_res = col_hit ? on_box : (par_reg ^ meet);
                end else begin
                    if (s1_vld_reg && meet) begin
                        par_next = !par_reg;
                    end
                    if (issue_reg < n_reg) begin
                        rd_en      = 1'b1;
                        issue_next = issue_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Edge former: pairs each vertex with the one before, then closes the ring.
    always_comb
    begin
        e_vld_next = 1'b0;
        wrap_next  = 1'b0;
        if (!finish) begin
            if (rd_vld_reg) begin
                if (rd_idx_reg == '0) begin
                    wrap_next = (n_reg == CW'(1));
                end else begin
                    e_vld_next = 1'b1;
                    wrap_next  = (CW'(rd_idx_reg) == n_reg - CW'(1));
                end
            end else if (wrap_reg) begin
                e_vld_next = 1'b1;
            end
        end
    end

    // Control register update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            closed_reg <= 1'b0;
            n_reg      <= '0;
            issue_reg  <= '0;
            par_reg    <= 1'b0;
            done_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            wrap_reg   <= 1'b0;
            e_vld_reg  <= 1'b0;
            s1_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            n_reg      <= n_next;
            issue_reg  <= issue_next;
            par_reg    <= par_next;
            done_reg   <= done_next;
            rd_vld_reg <= rd_en;
            wrap_reg   <= wrap_next;
            e_vld_reg  <= e_vld_next;
            s1_vld_reg <= e_vld_reg && !finish;
        end
    end

    // Vertex memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            vtx_mem[cnt_base[AW-1:0]] <= {item.coord_x, item.coord_y};
        end
        if (rd_en) begin
            rd_data_reg <= vtx_mem[issue_reg[AW-1:0]];
        end
    end

    // Result payload and query point.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (rd_en) begin
            rd_idx_reg <= issue_reg[AW-1:0];
        end
        if (accept && (item.mode == MODE_QUERY)) begin
            qx_reg <= in_x;
            qy_reg <= in_y;
        end
    end

    // Edge register payload.
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg) begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            if (rd_idx_reg == '0) begin
                first_x_reg <= rd_x;
                first_y_reg <= rd_y;
            end
            ea_x_reg   <= prev_x_reg;
            ea_y_reg   <= prev_y_reg;
            eb_x_reg   <= rd_x;
            eb_y_reg   <= rd_y;
            e_last_reg <= 1'b0;
        end else if (wrap_reg) begin
            ea_x_reg   <= prev_x_reg;
            ea_y_reg   <= prev_y_reg;
            eb_x_reg   <= first_x_reg;
            eb_y_reg   <= first_y_reg;
            e_last_reg <= 1'b1;
        end
    end

    // Stage one: differences and the five cross-term products.
    logic signed [DW-1:0] d_by_ay, d_px_bx, d_bx_ax, d_py_by, d_fx_bx;
    logic signed [DW-1:0] d_py_ay, d_bx_px, d_px_ax;

    assign d_by_ay = DW'(eb_y_reg) - DW'(ea_y_reg);
    assign d_px_bx = DW'(qx_reg) - DW'(eb_x_reg);
    assign d_bx_ax = DW'(eb_x_reg) - DW'(ea_x_reg);
    assign d_py_by = DW'(qy_reg) - DW'(eb_y_reg);
    assign d_fx_bx = DW'(FAR_X) - DW'(eb_x_reg);
    assign d_py_ay = DW'(qy_reg) - DW'(ea_y_reg);
    assign d_bx_px = DW'(eb_x_reg) - DW'(qx_reg);
    assign d_px_ax = DW'(qx_reg) - DW'(ea_x_reg);

    always_ff @(posedge clk)
    begin
        if (e_vld_reg) begin
            m1a_reg     <= PW'(d_by_ay) * PW'(d_px_bx);
            m1b_reg     <= PW'(d_bx_ax) * PW'(d_py_by);
            m2a_reg     <= PW'(d_by_ay) * PW'(d_fx_bx);
            m5a_reg     <= PW'(d_py_ay) * PW'(d_bx_px);
            m5b_reg     <= PW'(d_px_ax) * (-PW'(d_py_by));
            sa_x_reg    <= ea_x_reg;
            sa_y_reg    <= ea_y_reg;
            sb_x_reg    <= eb_x_reg;
            sb_y_reg    <= eb_y_reg;
            s1_last_reg <= e_last_reg;
        end
    end

    // A result strobe never overlaps a running query.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // A query on a non-empty table starts the edge walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode == MODE_QUERY) && (count_reg != '0)) |=> busy)
        else $error("query did not start");

    // The vertex count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count overflow");

    // Reads stay below the snapshot of the vertex count.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_reg < n_reg))
        else $error("vertex read beyond count");

endmodule

`default_nettype wire
